// ===== hw/rtl/sdr_pkg.sv =====
// ----------------------------------------------------------------------------
// sdr_pkg
// Shared types and constants of the sliding-window detrended RMS block.
// ----------------------------------------------------------------------------
package sdr_pkg;

  localparam int TIME_W = 20;
  localparam int PROF_W = 24;
  localparam int FLUC_W = 24;
  localparam int IDX_W  = 20;
  localparam int CFG_W  = 11;

  // datapath of the shared shift-add unit
  localparam int DW    = 128;
  localparam int MB_W  = 64;
  localparam int CNT_W = 8;
  localparam int Q_W   = 2 * FLUC_W;
  localparam int OP_W  = 4;

  localparam logic [CFG_W-1:0]  LEN_RST  = 11'd16;
  localparam logic [FLUC_W-1:0] FLUC_MAX = 24'hFFFFFF;

  typedef struct packed {
    logic [TIME_W-1:0]        time_value;
    logic signed [PROF_W-1:0] profile_value;
    logic                     last_sample;
  } in_t;

  typedef struct packed {
    logic [FLUC_W-1:0] fluctuation;
    logic [IDX_W-1:0]  window_index;
    logic              degenerate;
  } out_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SUM,
    ST_LOAD,
    ST_MUL,
    ST_STORE,
    ST_DIV,
    ST_ROOT,
    ST_OUT,
    ST_FIN
  } state_t;

  // multiply-accumulate steps, run in this order
  typedef enum logic [OP_W-1:0] {
    OP_TT_OLD,
    OP_TT_NEW,
    OP_YY_OLD,
    OP_YY_NEW,
    OP_TY_OLD,
    OP_TY_NEW,
    OP_A_L,
    OP_A_SQ,
    OP_C_L,
    OP_C_SQ,
    OP_B_L,
    OP_B_SQ,
    OP_AC,
    OP_BB,
    OP_L2,
    OP_DEN
  } op_t;

endpackage

// ===== hw/rtl/sdr_ram.sv =====
// ----------------------------------------------------------------------------
// sdr_ram
// Generic simple dual-port RAM, one write port, one registered read port.
// ----------------------------------------------------------------------------
module sdr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== hw/rtl/sliding_window_detrended_rms.sv =====
// ----------------------------------------------------------------------------
// sliding_window_detrended_rms
// RMS residual of a least-squares line fit over a sliding window of samples.
// ----------------------------------------------------------------------------
// Input beats carry (time_value, profile_value, last_sample) on in_valid /
// in_stall. Once the window holds window_len samples, each input beat gives
// one output beat on out_valid / out_stall with the Q24.0 fluctuation, the
// index of the window's first sample and a degenerate flag (all times equal).
// last_sample clears the window after its own result. A write on cfg_we sets
// window_len (clamped to 2..WINDOW_MAX) and clears the window.
// One item is worked on at a time; in_stall is high from acceptance until
// the block is idle again. The work runs on one shift-add unit that retires
// one multiplier bit per cycle. While the window fills, a beat runs the six
// multiply-accumulates for the sums; a degenerate window stops after eight;
// a full window runs sixteen multiply-accumulates, a 128-step restoring
// divide and a 24-step square root.
// The result sits in an output register; a stalled receiver holds the block
// in its result state until that register frees up. Synchronous reset sets
// window_len to 16 and empties the window; the sample stores need no clear.
// ----------------------------------------------------------------------------
module sliding_window_detrended_rms #(
  parameter int WINDOW_MAX = 1024
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  output logic                     in_stall,
  input  sdr_pkg::in_t             in_data,
  output logic                     out_valid,
  input  logic                     out_stall,
  output sdr_pkg::out_t            out_data,
  input  logic                     cfg_we,
  input  logic [sdr_pkg::CFG_W-1:0] cfg_wdata
);

  localparam int LW     = $clog2(WINDOW_MAX + 1);
  localparam int AW     = $clog2(WINDOW_MAX);
  localparam int ST_W   = sdr_pkg::TIME_W + LW - 1;
  localparam int STT_W  = 2 * sdr_pkg::TIME_W + LW - 1;
  localparam int SY_W   = sdr_pkg::PROF_W + LW - 1;
  localparam int SYY_W  = 2 * sdr_pkg::PROF_W + LW - 2;
  localparam int STY_W  = sdr_pkg::TIME_W + sdr_pkg::PROF_W + LW;
  localparam int DW     = sdr_pkg::DW;
  localparam int MB_W   = sdr_pkg::MB_W;
  localparam int CNT_W  = sdr_pkg::CNT_W;
  localparam int Q_W    = sdr_pkg::Q_W;
  localparam int TW     = sdr_pkg::TIME_W;
  localparam int PW     = sdr_pkg::PROF_W;
  localparam int FW     = sdr_pkg::FLUC_W;

  sdr_pkg::state_t state_r, state_nxt;
  sdr_pkg::op_t    op_r, op_nxt;

  logic [sdr_pkg::CFG_W-1:0] len_r, len_nxt;
  logic [LW-1:0]             len_eff;
  logic [LW-1:0]             fill_r, fill_nxt;
  logic [AW-1:0]             wp_r, wp_nxt;
  logic [AW-1:0]             wpos;
  logic [sdr_pkg::IDX_W-1:0] widx_r, widx_nxt;

  logic [ST_W-1:0]          st_r, st_nxt;
  logic [STT_W-1:0]         stt_r, stt_nxt;
  logic signed [SY_W-1:0]   sy_r, sy_nxt;
  logic [SYY_W-1:0]         syy_r, syy_nxt;
  logic signed [STY_W-1:0]  sty_r, sty_nxt;

  logic [TW-1:0]            t_r, t_nxt;
  logic signed [PW-1:0]     y_r, y_nxt;
  logic                     last_r, last_nxt;
  logic [TW-1:0]            old_t_r, old_t_nxt;
  logic signed [PW-1:0]     old_y_r, old_y_nxt;

  logic [DW-1:0]   acc_r, acc_nxt;
  logic [DW-1:0]   mcand_r, mcand_nxt;
  logic [MB_W-1:0] mplier_r, mplier_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic            sub_r, sub_nxt;

  logic [MB_W-1:0]  a_r, a_nxt;
  logic [DW-1:0]    c_r, c_nxt;
  logic [MB_W-1:0]  b_r, b_nxt;
  logic [2*LW-1:0]  l2_r, l2_nxt;
  logic [DW-1:0]    num_r, num_nxt;
  logic [DW-1:0]    den_r, den_nxt;
  logic [DW-1:0]    rem_r, rem_nxt;
  logic [Q_W-1:0]   q_r, q_nxt;
  logic             sat_r, sat_nxt;
  logic [Q_W-1:0]   sq_x_r, sq_x_nxt;
  logic [Q_W-1:0]   sq_res_r, sq_res_nxt;
  logic [Q_W-1:0]   sq_bit_r, sq_bit_nxt;
  logic [FW-1:0]    fl_r, fl_nxt;
  logic             dg_r, dg_nxt;

  logic          out_valid_r, out_valid_nxt;
  sdr_pkg::out_t out_data_r, out_data_nxt;

  // load values of the next multiply-accumulate
  logic            ld_keep;
  logic [DW-1:0]   ld_acc;
  logic [DW-1:0]   ld_a;
  logic [MB_W-1:0] ld_b;
  logic [CNT_W-1:0] ld_n;
  logic            ld_sub;

  logic [TW-1:0]        ram_t_rdata;
  logic [PW-1:0]        ram_y_rdata;
  logic                 ram_we;
  logic                 full_before;
  logic                 out_free;
  logic [PW-1:0]        y_mag;
  logic [PW-1:0]        old_y_mag;
  logic [SY_W-1:0]      sy_mag;

  // --------------------------------------------------------------------------
  // sample stores
  // --------------------------------------------------------------------------
  assign wpos   = (LW'(wp_r) < len_eff) ? wp_r : '0;
  assign ram_we = (state_r == sdr_pkg::ST_SUM);

  sdr_ram #(
    .WIDTH(TW),
    .DEPTH(WINDOW_MAX)
  ) u_time_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(wpos),
    .wdata(t_r),
    .raddr(wpos),
    .rdata(ram_t_rdata)
  );

  sdr_ram #(
    .WIDTH(PW),
    .DEPTH(WINDOW_MAX)
  ) u_prof_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(wpos),
    .wdata(y_r),
    .raddr(wpos),
    .rdata(ram_y_rdata)
  );

  // --------------------------------------------------------------------------
  // misc combinational
  // --------------------------------------------------------------------------
  always_comb begin
    if (len_r < 2) begin
      len_eff = LW'(2);
    end else if (int'(len_r) > WINDOW_MAX) begin
      len_eff = LW'(WINDOW_MAX);
    end else begin
      len_eff = LW'(len_r);
    end
  end

  assign full_before = (fill_r >= len_eff);
  assign out_free    = !out_valid_r || !out_stall;
  assign y_mag       = y_r[PW-1] ? PW'(-y_r) : PW'(y_r);
  assign old_y_mag   = old_y_r[PW-1] ? PW'(-old_y_r) : PW'(old_y_r);
  assign sy_mag      = sy_r[SY_W-1] ? SY_W'(-sy_r) : SY_W'(sy_r);

  assign in_stall  = (state_r != sdr_pkg::ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // operand selection per step
  always_comb begin
    ld_keep = 1'b1;
    ld_acc  = '0;
    ld_a    = '0;
    ld_b    = '0;
    ld_n    = CNT_W'(1);
    ld_sub  = 1'b0;
    case (op_r)
      sdr_pkg::OP_TT_OLD: begin
        ld_keep = 1'b0;
        ld_acc  = DW'(stt_r);
        ld_a    = DW'(old_t_r);
        ld_b    = MB_W'(old_t_r);
        ld_n    = CNT_W'(TW);
        ld_sub  = 1'b1;
      end
      sdr_pkg::OP_TT_NEW: begin
        ld_a = DW'(t_r);
        ld_b = MB_W'(t_r);
        ld_n = CNT_W'(TW);
      end
      sdr_pkg::OP_YY_OLD: begin
        ld_keep = 1'b0;
        ld_acc  = DW'(syy_r);
        ld_a    = DW'(old_y_mag);
        ld_b    = MB_W'(old_y_mag);
        ld_n    = CNT_W'(PW);
        ld_sub  = 1'b1;
      end
      sdr_pkg::OP_YY_NEW: begin
        ld_a = DW'(y_mag);
        ld_b = MB_W'(y_mag);
        ld_n = CNT_W'(PW);
      end
      sdr_pkg::OP_TY_OLD: begin
        ld_keep = 1'b0;
        ld_acc  = DW'(sty_r);
        ld_a    = DW'(old_y_r);
        ld_b    = MB_W'(old_t_r);
        ld_n    = CNT_W'(TW);
        ld_sub  = 1'b1;
      end
      sdr_pkg::OP_TY_NEW: begin
        ld_a = DW'(y_r);
        ld_b = MB_W'(t_r);
        ld_n = CNT_W'(TW);
      end
      sdr_pkg::OP_A_L: begin
        ld_keep = 1'b0;
        ld_a    = DW'(stt_r);
        ld_b    = MB_W'(len_eff);
        ld_n    = CNT_W'(LW);
      end
      sdr_pkg::OP_A_SQ: begin
        ld_a   = DW'(st_r);
        ld_b   = MB_W'(st_r);
        ld_n   = CNT_W'(ST_W);
        ld_sub = 1'b1;
      end
      sdr_pkg::OP_C_L: begin
        ld_keep = 1'b0;
        ld_a    = DW'(syy_r);
        ld_b    = MB_W'(len_eff);
        ld_n    = CNT_W'(LW);
      end
      sdr_pkg::OP_C_SQ: begin
        ld_a   = DW'(sy_mag);
        ld_b   = MB_W'(sy_mag);
        ld_n   = CNT_W'(SY_W);
        ld_sub = 1'b1;
      end
      sdr_pkg::OP_B_L: begin
        ld_keep = 1'b0;
        ld_a    = DW'(sty_r);
        ld_b    = MB_W'(len_eff);
        ld_n    = CNT_W'(LW);
      end
      sdr_pkg::OP_B_SQ: begin
        ld_a   = DW'(sy_r);
        ld_b   = MB_W'(st_r);
        ld_n   = CNT_W'(ST_W);
        ld_sub = 1'b1;
      end
      sdr_pkg::OP_AC: begin
        ld_keep = 1'b0;
        ld_a    = c_r;
        ld_b    = a_r;
        ld_n    = CNT_W'(MB_W);
      end
      sdr_pkg::OP_BB: begin
        ld_a   = DW'(b_r);
        ld_b   = b_r;
        ld_n   = CNT_W'(MB_W);
        ld_sub = 1'b1;
      end
      sdr_pkg::OP_L2: begin
        ld_keep = 1'b0;
        ld_a    = DW'(len_eff);
        ld_b    = MB_W'(len_eff);
        ld_n    = CNT_W'(LW);
      end
      sdr_pkg::OP_DEN: begin
        ld_keep = 1'b0;
        ld_a    = DW'(a_r);
        ld_b    = MB_W'(l2_r);
        ld_n    = CNT_W'(2 * LW);
      end
      default: begin
        ld_keep = 1'b1;
      end
    endcase
  end

  // --------------------------------------------------------------------------
  // next state
  // --------------------------------------------------------------------------
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      sdr_pkg::ST_IDLE: begin
        if (in_valid) begin
          state_nxt = sdr_pkg::ST_SUM;
        end
      end
      sdr_pkg::ST_SUM: begin
        state_nxt = sdr_pkg::ST_LOAD;
      end
      sdr_pkg::ST_LOAD: begin
        state_nxt = sdr_pkg::ST_MUL;
      end
      sdr_pkg::ST_MUL: begin
        if (cnt_r == CNT_W'(1)) begin
          state_nxt = sdr_pkg::ST_STORE;
        end
      end
      sdr_pkg::ST_STORE: begin
        case (op_r)
          sdr_pkg::OP_TY_NEW: begin
            state_nxt = (fill_r >= len_eff) ? sdr_pkg::ST_LOAD : sdr_pkg::ST_FIN;
          end
          sdr_pkg::OP_A_SQ: begin
            state_nxt = (acc_r == '0) ? sdr_pkg::ST_OUT : sdr_pkg::ST_LOAD;
          end
          sdr_pkg::OP_DEN: begin
            state_nxt = sdr_pkg::ST_DIV;
          end
          default: begin
            state_nxt = sdr_pkg::ST_LOAD;
          end
        endcase
      end
      sdr_pkg::ST_DIV: begin
        if (cnt_r == CNT_W'(1)) begin
          state_nxt = sdr_pkg::ST_ROOT;
        end
      end
      sdr_pkg::ST_ROOT: begin
        if (cnt_r == CNT_W'(1)) begin
          state_nxt = sdr_pkg::ST_OUT;
        end
      end
      sdr_pkg::ST_OUT: begin
        if (out_free) begin
          state_nxt = sdr_pkg::ST_FIN;
        end
      end
      sdr_pkg::ST_FIN: begin
        state_nxt = sdr_pkg::ST_IDLE;
      end
      default: begin
        state_nxt = sdr_pkg::ST_IDLE;
      end
    endcase
  end

  // --------------------------------------------------------------------------
  // datapath
  // --------------------------------------------------------------------------
  always_comb begin
    logic [DW:0]     shifted;
    logic            qbit;
    logic [Q_W-1:0]  trial;
    logic [MB_W-1:0] acc_lo;

    op_nxt        = op_r;
    len_nxt       = len_r;
    fill_nxt      = fill_r;
    wp_nxt        = wp_r;
    widx_nxt      = widx_r;
    st_nxt        = st_r;
    stt_nxt       = stt_r;
    sy_nxt        = sy_r;
    syy_nxt       = syy_r;
    sty_nxt       = sty_r;
    t_nxt         = t_r;
    y_nxt         = y_r;
    last_nxt      = last_r;
    old_t_nxt     = old_t_r;
    old_y_nxt     = old_y_r;
    acc_nxt       = acc_r;
    mcand_nxt     = mcand_r;
    mplier_nxt    = mplier_r;
    cnt_nxt       = cnt_r;
    sub_nxt       = sub_r;
    a_nxt         = a_r;
    c_nxt         = c_r;
    b_nxt         = b_r;
    l2_nxt        = l2_r;
    num_nxt       = num_r;
    den_nxt       = den_r;
    rem_nxt       = rem_r;
    q_nxt         = q_r;
    sat_nxt       = sat_r;
    sq_x_nxt      = sq_x_r;
    sq_res_nxt    = sq_res_r;
    sq_bit_nxt    = sq_bit_r;
    fl_nxt        = fl_r;
    dg_nxt        = dg_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;

    shifted = {rem_r, num_r[DW-1]};
    qbit    = (shifted >= {1'b0, den_r});
    trial   = sq_res_r + sq_bit_r;
    acc_lo  = acc_r[MB_W-1:0];

    // drop the output beat once taken
    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      sdr_pkg::ST_IDLE: begin
        if (in_valid) begin
          t_nxt    = in_data.time_value;
          y_nxt    = in_data.profile_value;
          last_nxt = in_data.last_sample;
        end
      end
      sdr_pkg::ST_SUM: begin
        // evict the oldest sample only with a full window
        old_t_nxt = full_before ? ram_t_rdata : '0;
        old_y_nxt = full_before ? PW'(ram_y_rdata) : '0;
        st_nxt    = st_r - (full_before ? ST_W'(ram_t_rdata) : '0) + ST_W'(t_r);
        sy_nxt    = sy_r - (full_before ? SY_W'($signed(ram_y_rdata)) : '0)
                    + SY_W'(y_r);
        wp_nxt    = ((LW'(wpos) + LW'(1)) >= len_eff) ? '0 : AW'(wpos + AW'(1));
        if (!full_before) begin
          fill_nxt = fill_r + LW'(1);
        end
        op_nxt = sdr_pkg::OP_TT_OLD;
      end
      sdr_pkg::ST_LOAD: begin
        acc_nxt    = ld_keep ? acc_r : ld_acc;
        mcand_nxt  = ld_a;
        mplier_nxt = ld_b;
        cnt_nxt    = ld_n;
        sub_nxt    = ld_sub;
      end
      sdr_pkg::ST_MUL: begin
        if (mplier_r[0]) begin
          acc_nxt = sub_r ? (acc_r - mcand_r) : (acc_r + mcand_r);
        end
        mcand_nxt  = mcand_r << 1;
        mplier_nxt = mplier_r >> 1;
        cnt_nxt    = cnt_r - CNT_W'(1);
      end
      sdr_pkg::ST_STORE: begin
        op_nxt = sdr_pkg::op_t'(sdr_pkg::OP_W'(op_r) + sdr_pkg::OP_W'(1));
        case (op_r)
          sdr_pkg::OP_TT_NEW: stt_nxt = acc_r[STT_W-1:0];
          sdr_pkg::OP_YY_NEW: syy_nxt = acc_r[SYY_W-1:0];
          sdr_pkg::OP_TY_NEW: sty_nxt = acc_r[STY_W-1:0];
          sdr_pkg::OP_A_SQ: begin
            a_nxt  = acc_lo;
            fl_nxt = '0;
            dg_nxt = (acc_r == '0);
          end
          sdr_pkg::OP_C_SQ: c_nxt = acc_r;
          sdr_pkg::OP_B_SQ: b_nxt = acc_lo[MB_W-1] ? (~acc_lo + MB_W'(1)) : acc_lo;
          sdr_pkg::OP_BB:   num_nxt = acc_r[DW-1] ? '0 : acc_r;
          sdr_pkg::OP_L2:   l2_nxt = acc_r[2*LW-1:0];
          sdr_pkg::OP_DEN: begin
            den_nxt = acc_r;
            rem_nxt = '0;
            q_nxt   = '0;
            sat_nxt = 1'b0;
            cnt_nxt = CNT_W'(DW);
          end
          default: begin
            op_nxt = sdr_pkg::op_t'(sdr_pkg::OP_W'(op_r) + sdr_pkg::OP_W'(1));
          end
        endcase
      end
      sdr_pkg::ST_DIV: begin
        rem_nxt = qbit ? DW'(shifted - {1'b0, den_r}) : shifted[DW-1:0];
        num_nxt = num_r << 1;
        // quotient bits above the square-root range only mark saturation
        sat_nxt = sat_r | q_r[Q_W-1];
        q_nxt   = {q_r[Q_W-2:0], qbit};
        cnt_nxt = cnt_r - CNT_W'(1);
        if (cnt_r == CNT_W'(1)) begin
          sq_x_nxt   = {q_r[Q_W-2:0], qbit};
          sq_res_nxt = '0;
          sq_bit_nxt = Q_W'(1) << (Q_W - 2);
          cnt_nxt    = CNT_W'(FW);
        end
      end
      sdr_pkg::ST_ROOT: begin
        if (sq_x_r >= trial) begin
          sq_x_nxt   = sq_x_r - trial;
          sq_res_nxt = (sq_res_r >> 1) + sq_bit_r;
        end else begin
          sq_res_nxt = sq_res_r >> 1;
        end
        sq_bit_nxt = sq_bit_r >> 2;
        cnt_nxt    = cnt_r - CNT_W'(1);
        if (cnt_r == CNT_W'(1)) begin
          fl_nxt = sat_r ? sdr_pkg::FLUC_MAX : sq_res_nxt[FW-1:0];
          dg_nxt = 1'b0;
        end
      end
      sdr_pkg::ST_OUT: begin
        if (out_free) begin
          out_data_nxt.fluctuation  = fl_r;
          out_data_nxt.window_index = widx_r;
          out_data_nxt.degenerate   = dg_r;
          out_valid_nxt             = 1'b1;
          widx_nxt                  = widx_r + sdr_pkg::IDX_W'(1);
        end
      end
      sdr_pkg::ST_FIN: begin
        if (last_r) begin
          fill_nxt = '0;
          wp_nxt   = '0;
          widx_nxt = '0;
          st_nxt   = '0;
          stt_nxt  = '0;
          sy_nxt   = '0;
          syy_nxt  = '0;
          sty_nxt  = '0;
        end
      end
      default: begin
        op_nxt = op_r;
      end
    endcase

    if (cfg_we) begin
      len_nxt  = cfg_wdata;
      fill_nxt = '0;
      wp_nxt   = '0;
      widx_nxt = '0;
      st_nxt   = '0;
      stt_nxt  = '0;
      sy_nxt   = '0;
      syy_nxt  = '0;
      sty_nxt  = '0;
    end
  end

  // --------------------------------------------------------------------------
  // registers
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= sdr_pkg::ST_IDLE;
      op_r        <= sdr_pkg::OP_TT_OLD;
      out_valid_r <= 1'b0;
      len_r       <= sdr_pkg::LEN_RST;
      fill_r      <= '0;
      wp_r        <= '0;
      widx_r      <= '0;
      st_r        <= '0;
      stt_r       <= '0;
      sy_r        <= '0;
      syy_r       <= '0;
      sty_r       <= '0;
    end else begin
      state_r     <= state_nxt;
      op_r        <= op_nxt;
      out_valid_r <= out_valid_nxt;
      len_r       <= len_nxt;
      fill_r      <= fill_nxt;
      wp_r        <= wp_nxt;
      widx_r      <= widx_nxt;
      st_r        <= st_nxt;
      stt_r       <= stt_nxt;
      sy_r        <= sy_nxt;
      syy_r       <= syy_nxt;
      sty_r       <= sty_nxt;
    end
  end

  always_ff @(posedge clk) begin
    t_r        <= t_nxt;
    y_r        <= y_nxt;
    last_r     <= last_nxt;
    old_t_r    <= old_t_nxt;
    old_y_r    <= old_y_nxt;
    acc_r      <= acc_nxt;
    mcand_r    <= mcand_nxt;
    mplier_r   <= mplier_nxt;
    cnt_r      <= cnt_nxt;
    sub_r      <= sub_nxt;
    a_r        <= a_nxt;
    c_r        <= c_nxt;
    b_r        <= b_nxt;
    l2_r       <= l2_nxt;
    num_r      <= num_nxt;
    den_r      <= den_nxt;
    rem_r      <= rem_nxt;
    q_r        <= q_nxt;
    sat_r      <= sat_nxt;
    sq_x_r     <= sq_x_nxt;
    sq_res_r   <= sq_res_nxt;
    sq_bit_r   <= sq_bit_nxt;
    fl_r       <= fl_nxt;
    dg_r       <= dg_nxt;
    out_data_r <= out_data_nxt;
  end

  // --------------------------------------------------------------------------
  // assertions
  // --------------------------------------------------------------------------
  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= len_eff)
    else $error("fill count beyond window length");

  a_wp_bound: assert property (@(posedge clk) disable iff (!rst_n)
    LW'(wp_r) < len_eff)
    else $error("write position beyond window length");

  a_out_from_out: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r) == sdr_pkg::ST_OUT)
    else $error("output beat raised outside result state");

  a_degen_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_data_r.degenerate |-> out_data_r.fluctuation == '0)
    else $error("degenerate window with nonzero fluctuation");

  a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> state_r == sdr_pkg::ST_SUM)
    else $error("accepted beat did not start the sequencer");

endmodule
